// ===== hw/rtl/assert_macros.svh =====
// Assertion macros included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off while reset is low.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/dwgs_pkg.sv =====
// Shared types and constants of the damped wave grid block.
`timescale 1ns / 1ps

package dwgs_pkg;

    // Item actions
    typedef enum logic [1:0] {
        ACT_STEP  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;   // clearing pass after reset, one cell a cycle
        logic start;   // step accepted: restart scan counters and flag
        logic scan;    // issue one raster read of the step scan
        logic load;    // capture the accepted item
        logic host;    // single-cell read or write slot
        logic swap;    // exchange current and previous banks
    } t_cmd;

    localparam logic [15:0]        WAVE_COEFF_RESET = 16'd16384;
    localparam logic signed [15:0] CENTRE_HEIGHT    = 16'sd819;
    // Cycles from the last scan read to the last write-back
    localparam int                 PIPE_DRAIN       = 6;

endpackage

// ===== hw/rtl/dwgs_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module dwgs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/dwgs_ctrl.sv =====
// Controller: sequencing of clear, step scan and host access, plus result register.
`timescale 1ns / 1ps

module dwgs_ctrl #(
    parameter int GRID_SIZE = 64,
    localparam int Cells    = GRID_SIZE * GRID_SIZE,
    localparam int CW       = $clog2(Cells + GRID_SIZE + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [1:0]           i_action,
    output logic                 o_stall,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [15:0]   o_height_out,
    output logic                 o_saturated,
    input  logic signed [15:0]   i_res_height,
    input  logic                 i_res_sat,
    output dwgs_pkg::t_cmd       o_cmd,
    output logic [CW-1:0]        o_cnt
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_HOST,
        ST_FIN
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_step, n_step;
    logic               r_ov, n_ov;
    logic signed [15:0] r_hout, n_hout;
    logic               r_sat, n_sat;
    logic               w_fin_go;

    assign w_fin_go = (r_state == ST_FIN) && (!r_ov || !i_stall);

    // next state and result register
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_step  = r_step;
        n_ov    = r_ov;
        n_hout  = r_hout;
        n_sat   = r_sat;
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        case (r_state)
            ST_CLEAR: begin
                if (r_cnt == CW'(Cells - 1)) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_cnt = '0;
                    if (i_action == dwgs_pkg::ACT_STEP) begin
                        n_state = ST_SCAN;
                        n_step  = 1'b1;
                    end else begin
                        n_state = ST_HOST;
                        n_step  = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                if (r_cnt == CW'(Cells + GRID_SIZE - 1)) begin
                    n_state = ST_DRAIN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (r_cnt == CW'(dwgs_pkg::PIPE_DRAIN - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_HOST: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_fin_go) begin
                    n_state = ST_IDLE;
                    n_ov    = 1'b1;
                    n_hout  = i_res_height;
                    n_sat   = i_res_sat;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_step  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_ov    <= n_ov;
            r_hout  <= n_hout;
            r_sat   <= n_sat;
        end
    end

    // commands to the datapath
    always_comb begin
        o_cmd       = '0;
        o_cmd.clear = (r_state == ST_CLEAR);
        o_cmd.scan  = (r_state == ST_SCAN);
        o_cmd.host  = (r_state == ST_HOST);
        o_cmd.load  = (r_state == ST_IDLE) && i_valid;
        o_cmd.start = (r_state == ST_IDLE) && i_valid && (i_action == dwgs_pkg::ACT_STEP);
        o_cmd.swap  = w_fin_go && r_step;
    end

    assign o_cnt        = r_cnt;
    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = r_ov;
    assign o_height_out = r_hout;
    assign o_saturated  = r_sat;

endmodule

// ===== hw/rtl/dwgs_datapath.sv =====
// Datapath: height banks, neighbour shift line and the cell update pipeline.
`timescale 1ns / 1ps

module dwgs_datapath #(
    parameter int GRID_SIZE = 64,
    localparam int Cells    = GRID_SIZE * GRID_SIZE,
    localparam int AW       = $clog2(Cells),
    localparam int CW       = $clog2(Cells + GRID_SIZE + 1),
    localparam int RW       = $clog2(GRID_SIZE),
    localparam int Taps     = 2 * GRID_SIZE + 1,
    localparam int DampN    = GRID_SIZE / 2 + 1,
    localparam int MW       = $clog2(DampN),
    localparam int Span     = GRID_SIZE - 1,
    localparam int Den      = 10 * Span,
    localparam int Centre   = (GRID_SIZE / 2) * GRID_SIZE + GRID_SIZE / 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dwgs_pkg::t_cmd       i_cmd,
    input  logic [CW-1:0]        i_cnt,
    input  logic [1:0]           i_action,
    input  logic [5:0]           i_row,
    input  logic [5:0]           i_col,
    input  logic signed [15:0]   i_height_in,
    input  logic                 i_cfg_valid,
    input  logic [15:0]          i_cfg_data,
    output logic signed [15:0]   o_res_height,
    output logic                 o_res_sat
);

    // fade profile in Q0.16, indexed by folded edge distance
    function automatic logic [15:0] damp_of(input int m);
        longint k;
        k = 10 * longint'(m);
        if (k > Span) begin
            k = Span;
        end
        return 16'((64'(622592) * k + Den / 2) / Den);
    endfunction

    logic [15:0] w_damp_tab [DampN];
    for (genvar g = 0; g < DampN; g++) begin : g_damp
        assign w_damp_tab[g] = damp_of(g);
    end

    // configuration, bank select, latched item
    logic [15:0]         r_coeff;
    logic                r_bank;
    dwgs_pkg::t_action   r_act;
    logic [AW-1:0]       r_addr;
    logic                r_inside;
    logic signed [15:0]  r_hin;
    logic                w_inside;

    assign w_inside = (int'(i_row) < GRID_SIZE) && (int'(i_col) < GRID_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff <= dwgs_pkg::WAVE_COEFF_RESET;
            r_bank  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_coeff <= i_cfg_data;
            end
            if (i_cmd.swap) begin
                r_bank <= ~r_bank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act    <= dwgs_pkg::t_action'(i_action);
            r_addr   <= AW'(int'(i_row) * GRID_SIZE + int'(i_col));
            r_inside <= w_inside;
            r_hin    <= i_height_in;
        end
    end

    // scan issue: cell p = i - GRID_SIZE trails the raster read by one row
    logic [CW-1:0] w_pdiff;
    logic [AW-1:0] w_paddr;
    logic          w_pv;
    logic [RW-1:0] r_pr, r_pc;
    logic [RW-1:0] w_er, w_ec, w_m;
    logic [15:0]   w_damp;

    assign w_pdiff = i_cnt - CW'(GRID_SIZE);
    assign w_paddr = w_pdiff[AW-1:0];
    assign w_pv    = i_cmd.scan && (i_cnt >= CW'(GRID_SIZE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr <= '0;
            r_pc <= '0;
        end else if (i_cmd.start) begin
            r_pr <= '0;
            r_pc <= '0;
        end else if (w_pv) begin
            if (r_pc == RW'(GRID_SIZE - 1)) begin
                r_pc <= '0;
                r_pr <= r_pr + 1'b1;
            end else begin
                r_pc <= r_pc + 1'b1;
            end
        end
    end

    // folded distance to the nearest edge, border cells get a zero damping factor
    always_comb begin
        w_er   = (r_pr < RW'(Span) - r_pr) ? r_pr : RW'(Span) - r_pr;
        w_ec   = (r_pc < RW'(Span) - r_pc) ? r_pc : RW'(Span) - r_pc;
        w_m    = (w_er < w_ec) ? w_er : w_ec;
        w_damp = w_damp_tab[MW'(w_m)];
    end

    // bank ports seen as current and previous
    logic [15:0]   w_cur_rdata, w_prev_rdata;
    logic [AW-1:0] w_cur_raddr, w_cur_waddr, w_prev_raddr, w_prev_waddr;
    logic          w_cur_we, w_prev_we;
    logic [15:0]   w_cur_wdata, w_prev_wdata;
    logic [15:0]   w_b0_rdata, w_b1_rdata;

    // pipeline registers
    logic                r_iss1, r_pv1, r_pv2, r_pv3, r_pv4, r_pv5, r_pv6;
    logic [AW-1:0]       r_addr1, r_addr2, r_addr3, r_addr4, r_addr5, r_addr6;
    logic [15:0]         r_damp1, r_damp2, r_damp3, r_damp4;
    logic signed [15:0]  r_taps [Taps];
    logic signed [15:0]  r_prev2, r_prev3;
    logic signed [34:0]  r_asum3, r_bc3;
    logic signed [36:0]  r_br4;
    logic signed [35:0]  r_ph5;
    logic [33:0]         r_pl5;
    logic signed [53:0]  r_v6;
    logic                r_sat;

    // raster read issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss1 <= 1'b0;
            r_pv1  <= 1'b0;
            r_pv2  <= 1'b0;
            r_pv3  <= 1'b0;
            r_pv4  <= 1'b0;
            r_pv5  <= 1'b0;
            r_pv6  <= 1'b0;
        end else begin
            r_iss1 <= i_cmd.scan;
            r_pv1  <= w_pv;
            r_pv2  <= r_pv1;
            r_pv3  <= r_pv2;
            r_pv4  <= r_pv3;
            r_pv5  <= r_pv4;
            r_pv6  <= r_pv5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr1 <= w_paddr;
        r_damp1 <= w_damp;
        r_addr2 <= r_addr1;
        r_damp2 <= r_damp1;
        r_prev2 <= signed'(w_prev_rdata);
        r_addr3 <= r_addr2;
        r_damp3 <= r_damp2;
        r_prev3 <= r_prev2;
        r_addr4 <= r_addr3;
        r_damp4 <= r_damp3;
        r_addr5 <= r_addr4;
        r_addr6 <= r_addr5;
    end

    // neighbour shift line: newest at tap 0
    always_ff @(posedge i_clk) begin
        if (r_iss1) begin
            r_taps[0] <= signed'(w_cur_rdata);
            for (int k = 1; k < Taps; k++) begin
                r_taps[k] <= r_taps[k-1];
            end
        end
    end

    // stage A: neighbour sum and the two coefficient products
    logic signed [17:0] w_sum;
    logic signed [16:0] w_a;
    logic signed [18:0] w_b;
    logic signed [34:0] w_asum, w_bc;

    always_comb begin
        w_sum  = 18'(r_taps[0]) + 18'(r_taps[GRID_SIZE-1])
               + 18'(r_taps[GRID_SIZE+1]) + 18'(r_taps[2*GRID_SIZE]);
        w_a    = signed'({1'b0, r_coeff});
        w_b    = 19'sd131072 - signed'({1'b0, r_coeff, 2'b00});
        w_asum = w_a * w_sum;
        w_bc   = w_b * r_taps[GRID_SIZE];
    end

    // stage C split of the bracket for the damping product
    logic signed [18:0] w_bh;
    logic [17:0]        w_bl;
    assign w_bh = signed'(r_br4[36:18]);
    assign w_bl = r_br4[17:0];

    always_ff @(posedge i_clk) begin
        r_asum3 <= w_asum;
        r_bc3   <= w_bc;
        r_br4   <= 37'(r_asum3) + 37'(r_bc3) - (37'(r_prev3) <<< 16);
        r_ph5   <= w_bh * signed'({1'b0, r_damp4});
        r_pl5   <= w_bl * r_damp4;
        r_v6    <= (54'(r_ph5) <<< 18) + signed'({20'd0, r_pl5});
    end

    // stage E: round half away from zero to Q1.15 and clamp
    logic signed [53:0] w_rnd;
    logic signed [21:0] w_q;
    logic signed [15:0] w_new;
    logic               w_clamp;

    always_comb begin
        w_rnd   = r_v6 + (r_v6[53] ? 54'sd2147483647 : 54'sd2147483648);
        w_q     = signed'(w_rnd[53:32]);
        w_clamp = 1'b0;
        if (w_q > 22'sd32767) begin
            w_new   = 16'sd32767;
            w_clamp = 1'b1;
        end else if (w_q < -22'sd32768) begin
            w_new   = -16'sd32768;
            w_clamp = 1'b1;
        end else begin
            w_new = w_q[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (i_cmd.start) begin
            r_sat <= 1'b0;
        end else if (r_pv6 && w_clamp) begin
            r_sat <= 1'b1;
        end
    end

    // current bank: raster reads, host access, clearing with the centre pulse
    always_comb begin
        w_cur_raddr  = i_cmd.scan ? i_cnt[AW-1:0] : r_addr;
        w_cur_we     = i_cmd.clear
                     || (i_cmd.host && r_inside && (r_act == dwgs_pkg::ACT_WRITE));
        w_cur_waddr  = i_cmd.clear ? i_cnt[AW-1:0] : r_addr;
        if (i_cmd.clear) begin
            w_cur_wdata = (i_cnt[AW-1:0] == AW'(Centre)) ? dwgs_pkg::CENTRE_HEIGHT : 16'd0;
        end else begin
            w_cur_wdata = r_hin;
        end
        // previous bank: read ahead, new heights written over it
        w_prev_raddr = w_paddr;
        w_prev_we    = i_cmd.clear || r_pv6;
        w_prev_waddr = i_cmd.clear ? i_cnt[AW-1:0] : r_addr6;
        w_prev_wdata = i_cmd.clear ? 16'd0 : w_new;
    end

    dwgs_ram #(.WIDTH(16), .DEPTH(Cells)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (r_bank ? w_prev_we    : w_cur_we),
        .i_waddr (r_bank ? w_prev_waddr : w_cur_waddr),
        .i_wdata (r_bank ? w_prev_wdata : w_cur_wdata),
        .i_raddr (r_bank ? w_prev_raddr : w_cur_raddr),
        .o_rdata (w_b0_rdata)
    );

    dwgs_ram #(.WIDTH(16), .DEPTH(Cells)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (r_bank ? w_cur_we    : w_prev_we),
        .i_waddr (r_bank ? w_cur_waddr : w_prev_waddr),
        .i_wdata (r_bank ? w_cur_wdata : w_prev_wdata),
        .i_raddr (r_bank ? w_cur_raddr : w_prev_raddr),
        .o_rdata (w_b1_rdata)
    );

    assign w_cur_rdata  = r_bank ? w_b1_rdata : w_b0_rdata;
    assign w_prev_rdata = r_bank ? w_b0_rdata : w_b1_rdata;

    // result fields of the finished item
    assign o_res_height = (r_act == dwgs_pkg::ACT_READ && r_inside) ? signed'(w_cur_rdata)
                                                                    : 16'sd0;
    assign o_res_sat    = (r_act == dwgs_pkg::ACT_STEP) ? r_sat : 1'b0;

endmodule

// ===== hw/rtl/damped_wave_grid_step.sv =====
// Top level of the damped wave grid block.
`timescale 1ns / 1ps

// Damped 2-D wave grid. Holds a GRID_SIZE x GRID_SIZE grid of Q1.15 heights and
// the grid before it, in two RAM banks that swap roles after each step. A step
// item streams the current bank in raster order, then its first row once more,
// one cell a cycle through the single read port of the current bank; the
// saturated flag of its result tells whether any cell clamped. Read and write
// items use a single host access slot. After reset a clearing pass over every
// cell loads the initial grid; no item is taken meanwhile, configuration
// writes are. The result register lets the next item be accepted while a
// result waits on a stalled output.
module damped_wave_grid_step #(
    parameter int GRID_SIZE = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_action,
    input  logic [5:0]           i_row,
    input  logic [5:0]           i_col,
    input  logic signed [15:0]   i_height_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [15:0]   o_height_out,
    output logic                 o_saturated,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [15:0]          i_cfg_data
);

    localparam int Cells = GRID_SIZE * GRID_SIZE;
    localparam int CW    = $clog2(Cells + GRID_SIZE + 1);

    dwgs_pkg::t_cmd     w_cmd;
    logic [CW-1:0]      w_cnt;
    logic signed [15:0] w_res_height;
    logic               w_res_sat;

    // register write is always taken
    assign o_cfg_ready = 1'b1;

    dwgs_ctrl #(.GRID_SIZE(GRID_SIZE)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_action     (i_action),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_height_out (o_height_out),
        .o_saturated  (o_saturated),
        .i_res_height (w_res_height),
        .i_res_sat    (w_res_sat),
        .o_cmd        (w_cmd),
        .o_cnt        (w_cnt)
    );

    dwgs_datapath #(.GRID_SIZE(GRID_SIZE)) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cnt        (w_cnt),
        .i_action     (i_action),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_height_in  (i_height_in),
        .i_cfg_valid  (i_cfg_valid & o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_res_height (w_res_height),
        .o_res_sat    (w_res_sat)
    );

endmodule

// ===== hw/rtl/dwgs_checker.sv =====
// Port-level checker of the damped wave grid block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dwgs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic signed [15:0]  o_height_out,
    input logic                o_saturated
);

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_height_out) && $stable(o_saturated))

    // a saturated step result carries no height
    `ASSERT_IMPL(a_sat_no_height, i_clk, i_rst_n, o_valid && o_saturated, o_height_out == 16'sd0)

    // one item at a time: an accepted transfer makes the block busy
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

endmodule

bind damped_wave_grid_step dwgs_checker u_dwgs_checker (.*);
